// ===== rtl/mmrp_pkg.sv =====
// ----------------------------------------------------------------------------
// mmrp_pkg
// Shared types, codes and the CRC16/Modbus byte update for the meter
// response parser.
// ----------------------------------------------------------------------------
package mmrp_pkg;

  // Frame layout
  localparam int unsigned FRAME_LEN      = 25;
  localparam int unsigned CRC_BYTES      = 23;
  localparam int unsigned DATA_LEN       = 20;
  localparam int unsigned DATA_START     = 3;
  localparam int unsigned POS_W          = 5;
  localparam int unsigned DATA_IDX_W     = 5;

  localparam logic [POS_W-1:0] POS_FUNC     = POS_W'(1);
  localparam logic [POS_W-1:0] POS_COUNT    = POS_W'(2);
  localparam logic [POS_W-1:0] POS_DATA_LO  = POS_W'(DATA_START);
  localparam logic [POS_W-1:0] POS_DATA_HI  = POS_W'(DATA_START + DATA_LEN - 1);
  localparam logic [POS_W-1:0] POS_CRC_LO   = POS_W'(CRC_BYTES);
  localparam logic [POS_W-1:0] POS_LAST     = POS_W'(FRAME_LEN - 1);

  // Protocol constants
  localparam logic [7:0]  FC_READ_INPUT  = 8'h04;
  localparam logic [7:0]  COUNT_EXPECTED = 8'h14;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;

  // Input action codes
  typedef enum logic [1:0] {
    ACT_BYTE    = 2'd0,
    ACT_START   = 2'd1,
    ACT_TIMEOUT = 2'd2
  } action_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TIMEOUT   = 3'd1,
    ST_BAD_FC    = 3'd2,
    ST_BAD_COUNT = 3'd3,
    ST_BAD_CRC   = 3'd4
  } status_t;

  // One result item
  typedef struct packed {
    status_t     status;
    logic [15:0] voltage_tenths;
    logic [31:0] current_milliamps;
    logic [31:0] power_tenths_watt;
    logic [31:0] energy_wh;
    logic [15:0] frequency_tenths;
    logic [15:0] power_factor_hundredths;
  } result_t;

  // Frame tracking status seen by the top level
  typedef struct packed {
    logic             open;
    logic [POS_W-1:0] pos;
  } frame_stat_t;

  // Reflected CRC16 update over one byte, eight shift steps
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/mmrp_in_stage.sv =====
// ----------------------------------------------------------------------------
// mmrp_in_stage
// Input register: captures one transfer and holds it until the frame
// logic consumes it.
// ----------------------------------------------------------------------------
module mmrp_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  input  logic [7:0] in_rx_byte,
  input  logic       advance,
  output logic       item_valid,
  output logic [1:0] item_action,
  output logic [7:0] item_byte
);

  logic       valid_r, valid_nxt;
  logic [1:0] action_r;
  logic [7:0] byte_r;
  logic       take;

  // Accept when empty or when the held item leaves this cycle
  assign in_ready = !valid_r || advance;
  assign take     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    if (take) begin
      action_r <= in_action;
      byte_r   <= in_rx_byte;
    end
  end

  assign item_valid  = valid_r;
  assign item_action = action_r;
  assign item_byte   = byte_r;

endmodule

// ===== rtl/mmrp_frame.sv =====
// ----------------------------------------------------------------------------
// mmrp_frame
// Frame tracker: byte position, running CRC, header and data bytes, and the
// result decision on the last byte or on a timeout.
// ----------------------------------------------------------------------------
module mmrp_frame (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_valid,
  input  logic [1:0]            item_action,
  input  logic [7:0]            item_byte,
  input  logic                  advance,
  output logic                  res_valid,
  output mmrp_pkg::result_t     res,
  output mmrp_pkg::frame_stat_t stat
);

  logic                        open_r, open_nxt;
  logic [mmrp_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [15:0]                 crc_r, crc_nxt;
  logic [7:0]                  func_r, func_nxt;
  logic [7:0]                  count_r, count_nxt;
  logic [7:0]                  crc_lo_r, crc_lo_nxt;
  logic [7:0]                  data_r [mmrp_pkg::DATA_LEN];
  logic                        data_we;
  logic [mmrp_pkg::DATA_IDX_W-1:0] data_idx;
  logic                        is_byte;
  logic                        is_last;
  mmrp_pkg::status_t           last_status;
  mmrp_pkg::action_t           act;

  assign act     = mmrp_pkg::action_t'(item_action);
  assign is_byte = item_valid && (act == mmrp_pkg::ACT_BYTE) && open_r;
  assign is_last = is_byte && (pos_r == mmrp_pkg::POS_LAST);
  assign data_idx = mmrp_pkg::DATA_IDX_W'(pos_r - mmrp_pkg::POS_DATA_LO);
  assign data_we  = advance && is_byte &&
                    (pos_r inside {[mmrp_pkg::POS_DATA_LO:mmrp_pkg::POS_DATA_HI]});

  // Check function code, byte count, then CRC (high byte is the current one)
  always_comb begin
    if (func_r != mmrp_pkg::FC_READ_INPUT) begin
      last_status = mmrp_pkg::ST_BAD_FC;
    end else if (count_r != mmrp_pkg::COUNT_EXPECTED) begin
      last_status = mmrp_pkg::ST_BAD_COUNT;
    end else if (crc_r != {item_byte, crc_lo_r}) begin
      last_status = mmrp_pkg::ST_BAD_CRC;
    end else begin
      last_status = mmrp_pkg::ST_OK;
    end
  end

  // Next state and result
  always_comb begin
    open_nxt   = open_r;
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    func_nxt   = func_r;
    count_nxt  = count_r;
    crc_lo_nxt = crc_lo_r;
    res_valid  = 1'b0;
    res        = '0;
    if (item_valid) begin
      case (act)
        mmrp_pkg::ACT_START: begin
          open_nxt   = 1'b1;
          pos_nxt    = '0;
          crc_nxt    = mmrp_pkg::CRC_INIT;
          func_nxt   = '0;
          count_nxt  = '0;
          crc_lo_nxt = '0;
        end
        mmrp_pkg::ACT_TIMEOUT: begin
          if (open_r) begin
            open_nxt   = 1'b0;
            pos_nxt    = '0;
            res_valid  = 1'b1;
            res.status = mmrp_pkg::ST_TIMEOUT;
          end
        end
        mmrp_pkg::ACT_BYTE: begin
          if (open_r) begin
            if (pos_r < mmrp_pkg::POS_CRC_LO) begin
              crc_nxt = mmrp_pkg::crc16_update(crc_r, item_byte);
            end
            if (pos_r == mmrp_pkg::POS_FUNC) begin
              func_nxt = item_byte;
            end
            if (pos_r == mmrp_pkg::POS_COUNT) begin
              count_nxt = item_byte;
            end
            if (pos_r == mmrp_pkg::POS_CRC_LO) begin
              crc_lo_nxt = item_byte;
            end
            if (is_last) begin
              open_nxt   = 1'b0;
              pos_nxt    = '0;
              res_valid  = 1'b1;
              res.status = last_status;
              if (last_status == mmrp_pkg::ST_OK) begin
                res.voltage_tenths          = {data_r[0],  data_r[1]};
                res.current_milliamps       = {data_r[4],  data_r[5],  data_r[2],  data_r[3]};
                res.power_tenths_watt       = {data_r[8],  data_r[9],  data_r[6],  data_r[7]};
                res.energy_wh               = {data_r[12], data_r[13], data_r[10], data_r[11]};
                res.frequency_tenths        = {data_r[14], data_r[15]};
                res.power_factor_hundredths = {data_r[16], data_r[17]};
              end
            end else begin
              pos_nxt = pos_r + 1'b1;
            end
          end
        end
        default: begin
          // unused action code: drop
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r   <= 1'b0;
      pos_r    <= '0;
      crc_r    <= mmrp_pkg::CRC_INIT;
      func_r   <= '0;
      count_r  <= '0;
      crc_lo_r <= '0;
    end else if (advance) begin
      open_r   <= open_nxt;
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      func_r   <= func_nxt;
      count_r  <= count_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

  // Store data bytes
  always_ff @(posedge clk) begin
    if (data_we) begin
      data_r[data_idx] <= item_byte;
    end
  end

  assign stat.open = open_r;
  assign stat.pos  = pos_r;

endmodule

// ===== rtl/mmrp_out_stage.sv =====
// ----------------------------------------------------------------------------
// mmrp_out_stage
// Result register: holds one result until the receiver takes the transfer.
// ----------------------------------------------------------------------------
module mmrp_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  mmrp_pkg::result_t res,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_ready,
  output mmrp_pkg::result_t out_res
);

  logic              valid_r, valid_nxt;
  mmrp_pkg::result_t res_r;

  assign out_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== rtl/modbus_meter_response_parser.sv =====
// ----------------------------------------------------------------------------
// modbus_meter_response_parser
// Parses a 25-byte Modbus RTU read-input-registers response from an energy
// meter and reports status plus the raw register values.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): in_action selects a received byte
//   (in_rx_byte), a start of a new frame, or a receive timeout.
//   Result channel (out_valid/out_ready): one result per completed frame
//   (25th byte) or per timeout while a frame is open; status plus values,
//   values zero unless status is ok.
//   A result is produced from the item held in the input register and is
//   registered in the result register before it shows on out_valid.
//   Throughput: one item per cycle while no result is stalled; the CRC byte
//   update, eight unrolled shift steps, sits between the two registers.
//   Reset: no frame is open; received bytes are dropped until a start
//   action. Data bytes are not cleared.
//   Stall: while out_valid is high and out_ready low, the result is held;
//   items that yield no result still advance, and in_ready drops only when
//   the held item would produce a result into the full result register.
// ----------------------------------------------------------------------------
module modbus_meter_response_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [15:0] out_voltage_tenths,
  output logic [31:0] out_current_milliamps,
  output logic [31:0] out_power_tenths_watt,
  output logic [31:0] out_energy_wh,
  output logic [15:0] out_frequency_tenths,
  output logic [15:0] out_power_factor_hundredths
);

  logic                  item_valid;
  logic [1:0]            item_action;
  logic [7:0]            item_byte;
  logic                  advance;
  logic                  res_valid;
  logic                  out_free;
  mmrp_pkg::result_t     res;
  mmrp_pkg::result_t     out_res;
  mmrp_pkg::frame_stat_t stat;

  // Advance the held item unless its result would land on a full register
  assign advance = item_valid && (!res_valid || out_free);

  mmrp_in_stage u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_action   (in_action),
    .in_rx_byte  (in_rx_byte),
    .advance     (advance),
    .item_valid  (item_valid),
    .item_action (item_action),
    .item_byte   (item_byte)
  );

  mmrp_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid),
    .item_action (item_action),
    .item_byte   (item_byte),
    .advance     (advance),
    .res_valid   (res_valid),
    .res         (res),
    .stat        (stat)
  );

  mmrp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_status                  = out_res.status;
  assign out_voltage_tenths          = out_res.voltage_tenths;
  assign out_current_milliamps       = out_res.current_milliamps;
  assign out_power_tenths_watt       = out_res.power_tenths_watt;
  assign out_energy_wh               = out_res.energy_wh;
  assign out_frequency_tenths        = out_res.frequency_tenths;
  assign out_power_factor_hundredths = out_res.power_factor_hundredths;

  // Error results carry zero values
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != mmrp_pkg::ST_OK) |->
      (out_voltage_tenths == '0 && out_current_milliamps == '0 &&
       out_power_tenths_watt == '0 && out_energy_wh == '0 &&
       out_frequency_tenths == '0 && out_power_factor_hundredths == '0))
    else $error("error result with nonzero values");

  // Position stays inside the frame and is zero while closed
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.pos <= mmrp_pkg::POS_LAST) && (stat.open || stat.pos == '0))
    else $error("frame position out of range");

  // A produced result is presented on the next cycle
  a_res_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_valid) |=> out_valid)
    else $error("result lost");

endmodule

// ===== test/tb_modbus_meter_response_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modbus_meter_response_parser
// Self-checking bench for the meter response parser. A table of directed
// rows covers the ignored-input cases, timeouts, each status code and the
// value extremes. Random frames follow: mostly well-formed, some with broken
// fields, cut short, or mixed with noise. An in-bench model predicts every
// result, and each result transfer is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_modbus_meter_response_parser;
  import mmrp_pkg::*;

  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam int         VALUE_BITS  = 144;
  localparam int         PHASE_ITEMS = 385;
  localparam int         DRAIN_LIMIT = 2000;

  localparam result_t RES_OK_ONES  = {ST_OK, {VALUE_BITS{1'b1}}};
  localparam result_t RES_OK_ZEROS = {ST_OK, {VALUE_BITS{1'b0}}};

  typedef enum logic {ROW_ITEM, ROW_FRAME} row_kind_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_FIXED} check_kind_t;

  // One directed row: a single item, or a start plus nbytes frame bytes
  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  act;
    logic [7:0]  b;        // item byte, or data fill of a frame
    logic [4:0]  nbytes;
    logic [7:0]  fc;
    logic [7:0]  cnt;
    logic        rnd_data;
    logic        crc_ok;
    check_kind_t ck;       // applies to the item, or to the 25th frame byte
    result_t     r;
  } dir_row_t;

  typedef struct packed {
    check_kind_t ck;
    result_t     r;
  } table_check_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action  = ACT_BYTE;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [2:0]  out_status;
  logic [15:0] out_voltage_tenths;
  logic [31:0] out_current_milliamps;
  logic [31:0] out_power_tenths_watt;
  logic [31:0] out_energy_wh;
  logic [15:0] out_frequency_tenths;
  logic [15:0] out_power_factor_hundredths;

  int src_idle_pct = 33;
  int dst_idle_pct = 86;
  int error_count  = 0;
  int live_items   = 0;

  result_t      awaited_readings [$];
  table_check_t table_checks [$];
  dir_row_t     dir_table [$];
  logic [7:0]   frame_buf [FRAME_LEN];

  // Parser model state
  logic             mtr_open   = 1'b0;
  logic [POS_W-1:0] mtr_pos    = '0;
  logic [15:0]      mtr_crc    = CRC_INIT;
  logic [7:0]       mtr_func   = 8'h00;
  logic [7:0]       mtr_count  = 8'h00;
  logic [7:0]       mtr_crc_lo = 8'h00;
  logic [7:0]       mtr_data [DATA_LEN];

  modbus_meter_response_parser dut (
    .clk                         (clk),
    .rst_n                       (rst_n),
    .in_valid                    (in_valid),
    .in_ready                    (in_ready),
    .in_action                   (in_action),
    .in_rx_byte                  (in_rx_byte),
    .out_valid                   (out_valid),
    .out_ready                   (out_ready),
    .out_status                  (out_status),
    .out_voltage_tenths          (out_voltage_tenths),
    .out_current_milliamps       (out_current_milliamps),
    .out_power_tenths_watt       (out_power_tenths_watt),
    .out_energy_wh               (out_energy_wh),
    .out_frequency_tenths        (out_frequency_tenths),
    .out_power_factor_hundredths (out_power_factor_hundredths)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------

  // CRC16/Modbus, one input bit per step, LSB first
  function automatic logic [15:0] modbus_crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic logic [15:0] data_word(input int k);
    return {mtr_data[2*k], mtr_data[2*k+1]};
  endfunction

  function automatic result_t fail_result(input status_t s);
    return {s, {VALUE_BITS{1'b0}}};
  endfunction

  // Advance the model by one item; live is low when the item is ignored
  function automatic void meter_parse(input logic [1:0] act, input logic [7:0] b,
                                      output bit live, output bit has, output result_t r);
    status_t          st;
    logic [POS_W-1:0] pos;
    live = 1'b0;
    has  = 1'b0;
    r    = '0;
    case (act)
      ACT_START: begin
        live       = 1'b1;
        mtr_open   = 1'b1;
        mtr_pos    = '0;
        mtr_crc    = CRC_INIT;
        mtr_func   = 8'h00;
        mtr_count  = 8'h00;
        mtr_crc_lo = 8'h00;
      end
      ACT_TIMEOUT: begin
        if (mtr_open) begin
          live     = 1'b1;
          has      = 1'b1;
          mtr_open = 1'b0;
          mtr_pos  = '0;
          r        = fail_result(ST_TIMEOUT);
        end
      end
      ACT_BYTE: begin
        if (mtr_open) begin
          live = 1'b1;
          pos  = mtr_pos;
          if (pos < CRC_BYTES) mtr_crc = modbus_crc_byte(mtr_crc, b);
          if (pos == POS_FUNC) mtr_func = b;
          else if (pos == POS_COUNT) mtr_count = b;
          else if (pos >= POS_DATA_LO && pos <= POS_DATA_HI) mtr_data[pos - POS_DATA_LO] = b;
          else if (pos == POS_CRC_LO) mtr_crc_lo = b;

          if (pos != POS_LAST) begin
            mtr_pos = pos + 1'b1;
          end else begin
            // Close the frame and grade it in check order
            mtr_open = 1'b0;
            mtr_pos  = '0;
            has      = 1'b1;
            if (mtr_func != FC_READ_INPUT) st = ST_BAD_FC;
            else if (mtr_count != COUNT_EXPECTED) st = ST_BAD_COUNT;
            else if (mtr_crc != {b, mtr_crc_lo}) st = ST_BAD_CRC;
            else st = ST_OK;
            r = fail_result(st);
            if (st == ST_OK) begin
              r.voltage_tenths          = data_word(0);
              r.current_milliamps       = {data_word(2), data_word(1)};
              r.power_tenths_watt       = {data_word(4), data_word(3)};
              r.energy_wh               = {data_word(6), data_word(5)};
              r.frequency_tenths        = data_word(7);
              r.power_factor_hundredths = data_word(8);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  function automatic void note_error(input string msg);
    if (error_count < 10) $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) note_error($sformatf("%s expected %0h, got %0h", name, want, got));
  endfunction

  always @(posedge clk) begin : monitor
    result_t      got;
    result_t      want;
    result_t      pred;
    table_check_t tc;
    bit           live;
    bit           has;
    if (rst_n) begin
      // Check the result transfer before queueing anything from this edge
      if (out_valid && out_ready) begin
        got = {out_status, out_voltage_tenths, out_current_milliamps, out_power_tenths_watt,
               out_energy_wh, out_frequency_tenths, out_power_factor_hundredths};
        if (awaited_readings.size() == 0) begin
          note_error($sformatf("result with nothing expected, status %0d", out_status));
        end else begin
          want = awaited_readings.pop_front();
          check_field("status", want.status, got.status);
          check_field("voltage_tenths", want.voltage_tenths, got.voltage_tenths);
          check_field("current_milliamps", want.current_milliamps, got.current_milliamps);
          check_field("power_tenths_watt", want.power_tenths_watt, got.power_tenths_watt);
          check_field("energy_wh", want.energy_wh, got.energy_wh);
          check_field("frequency_tenths", want.frequency_tenths, got.frequency_tenths);
          check_field("power_factor_hundredths", want.power_factor_hundredths,
                      got.power_factor_hundredths);
        end
      end

      // Predict from the input transfer; directed rows may pin the outcome
      if (in_valid && in_ready) begin
        meter_parse(in_action, in_rx_byte, live, has, pred);
        if (live) live_items++;
        if (table_checks.size() != 0) begin
          tc = table_checks.pop_front();
          case (tc.ck)
            CHK_NONE:  has = 1'b0;
            CHK_FIXED: begin
              has  = 1'b1;
              pred = tc.r;
            end
            default: ;
          endcase
        end
        if (has) awaited_readings.push_back(pred);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------

  // Receiver stall pattern
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= dst_idle_pct);
  end

  // Hold random idle cycles, then present the item until it transfers
  task automatic send_item(input logic [1:0] act, input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_action  <= act;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and hold until every awaited result has transferred
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_readings.size() != 0);
  endtask

  function automatic logic [7:0] other_than(input logic [7:0] v);
    logic [7:0] x;
    x = 8'($urandom_range(255));
    return (x == v) ? ~x : x;
  endfunction

  // Fill frame_buf with a response; the CRC is broken in one bit on request
  task automatic build_frame(input logic [7:0] fc, input logic [7:0] cnt, input bit rnd_data,
                             input logic [7:0] fill, input bit crc_ok);
    logic [15:0] crc;
    int          pick_byte;
    int          pick_bit;
    frame_buf[0] = 8'($urandom_range(255));
    frame_buf[1] = fc;
    frame_buf[2] = cnt;
    for (int i = DATA_START; i < CRC_BYTES; i++) begin
      frame_buf[i] = rnd_data ? 8'($urandom_range(255)) : fill;
    end
    crc = CRC_INIT;
    for (int i = 0; i < CRC_BYTES; i++) crc = modbus_crc_byte(crc, frame_buf[i]);
    frame_buf[CRC_BYTES]     = crc[7:0];
    frame_buf[CRC_BYTES + 1] = crc[15:8];
    if (!crc_ok) begin
      pick_byte = CRC_BYTES + $urandom_range(1);
      pick_bit  = $urandom_range(7);
      frame_buf[pick_byte][pick_bit] = ~frame_buf[pick_byte][pick_bit];
    end
  endtask

  function automatic dir_row_t item_row(input logic [1:0] act, input logic [7:0] b,
                                        input check_kind_t ck, input result_t r);
    dir_row_t row;
    row      = '0;
    row.kind = ROW_ITEM;
    row.act  = act;
    row.b    = b;
    row.ck   = ck;
    row.r    = r;
    return row;
  endfunction

  function automatic dir_row_t frame_row(input int nbytes, input logic [7:0] fc,
                                         input logic [7:0] cnt, input bit rnd_data,
                                         input logic [7:0] fill, input bit crc_ok,
                                         input check_kind_t ck, input result_t r);
    dir_row_t row;
    row          = '0;
    row.kind     = ROW_FRAME;
    row.nbytes   = 5'(nbytes);
    row.fc       = fc;
    row.cnt      = cnt;
    row.rnd_data = rnd_data;
    row.b        = fill;
    row.crc_ok   = crc_ok;
    row.ck       = ck;
    row.r        = r;
    return row;
  endfunction

  task automatic run_row(input dir_row_t row);
    table_check_t model_chk;
    table_check_t row_chk;
    model_chk.ck = CHK_MODEL;
    model_chk.r  = '0;
    row_chk.ck   = row.ck;
    row_chk.r    = row.r;
    if (row.kind == ROW_ITEM) begin
      table_checks.push_back(row_chk);
      send_item(row.act, row.b);
    end else begin
      build_frame(row.fc, row.cnt, row.rnd_data, row.b, row.crc_ok);
      table_checks.push_back(model_chk);
      send_item(ACT_START, 8'($urandom_range(255)));
      for (int i = 0; i < row.nbytes; i++) begin
        table_checks.push_back((i == FRAME_LEN - 1) ? row_chk : model_chk);
        send_item(ACT_BYTE, frame_buf[i]);
      end
    end
  endtask

  // One random sequence: a full frame, a cut-short frame, or noise
  task automatic send_random_burst();
    int         pick;
    int         flaw;
    int         n;
    logic [7:0] fc;
    logic [7:0] cnt;
    pick = $urandom_range(99);
    fc   = FC_READ_INPUT;
    cnt  = COUNT_EXPECTED;
    if (pick < 72) begin
      // Full frame, mostly good; some carry a bad code, count or CRC
      flaw = $urandom_range(11);
      if (flaw == 0 || flaw == 3) fc = other_than(FC_READ_INPUT);
      if (flaw == 1 || flaw == 3) cnt = other_than(COUNT_EXPECTED);
      build_frame(fc, cnt, $urandom_range(7) != 0, $urandom_range(1) ? 8'hFF : 8'h00,
                  !(flaw == 2 || flaw == 3));
      send_item(ACT_START, 8'($urandom_range(255)));
      for (int i = 0; i < FRAME_LEN; i++) begin
        if ($urandom_range(29) == 0) send_item(ACT_UNUSED, 8'($urandom_range(255)));
        send_item(ACT_BYTE, frame_buf[i]);
      end
    end else if (pick < 84) begin
      // Cut the frame short; end it by timeout or leave it to the next start
      build_frame(fc, cnt, 1'b1, 8'h00, 1'b1);
      send_item(ACT_START, 8'($urandom_range(255)));
      n = $urandom_range(FRAME_LEN - 1);
      for (int i = 0; i < n; i++) send_item(ACT_BYTE, frame_buf[i]);
      if ($urandom_range(2) != 0) send_item(ACT_TIMEOUT, 8'($urandom_range(255)));
    end else begin
      n = $urandom_range(6, 1);
      repeat (n) send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin : stimulus
    int phase_goal;
    int wait_cycles;

    dir_table = {
      // Nothing open after reset: all ignored
      item_row(ACT_BYTE, 8'hFF, CHK_NONE, '0),
      item_row(ACT_TIMEOUT, 8'h00, CHK_NONE, '0),
      item_row(ACT_UNUSED, 8'hA5, CHK_NONE, '0),
      // Timeout right after a start, then again with the frame closed
      item_row(ACT_START, 8'h00, CHK_NONE, '0),
      item_row(ACT_TIMEOUT, 8'hFF, CHK_FIXED, fail_result(ST_TIMEOUT)),
      item_row(ACT_TIMEOUT, 8'h00, CHK_NONE, '0),
      // Value extremes, and a trailing byte after a completed frame
      frame_row(FRAME_LEN, FC_READ_INPUT, COUNT_EXPECTED, 1'b0, 8'hFF, 1'b1,
                CHK_FIXED, RES_OK_ONES),
      item_row(ACT_BYTE, 8'h00, CHK_NONE, '0),
      frame_row(FRAME_LEN, FC_READ_INPUT, COUNT_EXPECTED, 1'b0, 8'h00, 1'b1,
                CHK_FIXED, RES_OK_ZEROS),
      // Each error status, then the check order with several faults at once
      frame_row(FRAME_LEN, 8'h03, COUNT_EXPECTED, 1'b1, 8'h00, 1'b1,
                CHK_FIXED, fail_result(ST_BAD_FC)),
      frame_row(FRAME_LEN, FC_READ_INPUT, 8'h13, 1'b1, 8'h00, 1'b1,
                CHK_FIXED, fail_result(ST_BAD_COUNT)),
      frame_row(FRAME_LEN, FC_READ_INPUT, COUNT_EXPECTED, 1'b1, 8'h00, 1'b0,
                CHK_FIXED, fail_result(ST_BAD_CRC)),
      frame_row(FRAME_LEN, 8'hFF, 8'h00, 1'b1, 8'h00, 1'b0,
                CHK_FIXED, fail_result(ST_BAD_FC)),
      frame_row(FRAME_LEN, FC_READ_INPUT, 8'hEB, 1'b1, 8'h00, 1'b0,
                CHK_FIXED, fail_result(ST_BAD_COUNT)),
      // Unused code and timeout mid-frame, then a restart mid-frame
      frame_row(7, FC_READ_INPUT, COUNT_EXPECTED, 1'b1, 8'h00, 1'b1, CHK_MODEL, '0),
      item_row(ACT_UNUSED, 8'h5A, CHK_NONE, '0),
      item_row(ACT_TIMEOUT, 8'h00, CHK_FIXED, fail_result(ST_TIMEOUT)),
      frame_row(12, FC_READ_INPUT, COUNT_EXPECTED, 1'b1, 8'h00, 1'b1, CHK_MODEL, '0),
      frame_row(FRAME_LEN, FC_READ_INPUT, COUNT_EXPECTED, 1'b1, 8'h00, 1'b1, CHK_MODEL, '0)
    };

    for (int i = 0; i < DATA_LEN; i++) mtr_data[i] = 8'h00;

    // Reset once
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[i]) run_row(dir_table[i]);
    hold_until_drained();

    // Random traffic under three idle patterns, draining between them
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 33;
          dst_idle_pct = 86;
        end
        1: begin
          src_idle_pct = 86;
          dst_idle_pct = 33;
        end
        default: begin
          src_idle_pct = 0;
          dst_idle_pct = 0;
        end
      endcase
      phase_goal = live_items + PHASE_ITEMS;
      while (live_items < phase_goal) send_random_burst();
      hold_until_drained();
    end

    // Wait out any stragglers, then keep watching for unexpected results
    wait_cycles = 0;
    while (awaited_readings.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (4) @(posedge clk);
    if (awaited_readings.size() != 0) begin
      note_error($sformatf("%0d results never arrived", awaited_readings.size()));
    end

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
